### rtl/core/pfa_pkg.sv
// Package for the priority focus arbiter.
// Holds sizes, the command codes, the request/result structs and the slot encoder.
// Used by every module in rtl/core.
package pfa_pkg;

    localparam int SLOTS    = 10;
    localparam int PRIO_MAX = 15;
    localparam int ID_W     = 8;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int PRIO_W   = $clog2(PRIO_MAX + 1);

    typedef logic [ID_W-1:0]   t_id;
    typedef logic [SLOTS-1:0]  t_slot_vec;
    typedef logic [SLOT_W-1:0] t_slot_idx;
    typedef logic [PRIO_W-1:0] t_prio;

    localparam t_id   ID_MAX        = {ID_W{1'b1}};
    localparam t_id   PRIO_MAX_ID   = ID_W'(PRIO_MAX);
    localparam t_prio PRIO_MAX_P    = PRIO_W'(PRIO_MAX);
    localparam t_prio PRIO_REGISTER = PRIO_W'(1);

    typedef enum logic [2:0] {
        CMD_REGISTER   = 3'd0,
        CMD_UNREGISTER = 3'd1,
        CMD_REQUEST    = 3'd2,
        CMD_RELEASE    = 3'd3,
        CMD_QUERY      = 3'd4,
        CMD_SET_PRIO   = 3'd5,
        CMD_INC_PRIO   = 3'd6,
        CMD_DEC_PRIO   = 3'd7
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
        t_id  app_id;
        t_id  priority_req;
    } t_request;

    typedef struct packed {
        logic ok;
        t_id  new_id;
        logic focus_valid;
        t_id  focus_holder;
        logic lost_valid;
        t_id  lost_id;
        logic gained_valid;
        t_id  gained_id;
    } t_result;

    // Index of the lowest set bit; zero when no bit is set.
    function automatic t_slot_idx first_set(input t_slot_vec v);
        t_slot_idx idx;
        idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = SLOT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

### rtl/core/pfa_in_reg.sv
// Input register stage of the priority focus arbiter.
// Captures one request and holds it until the command engine executes it.
// Depends on pfa_pkg.
module pfa_in_reg
    import pfa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic [2:0] i_cmd,
    input  t_id      i_app_id,
    input  t_id      i_priority_req,
    input  logic     i_out_free,
    output logic     o_stall,
    output logic     o_exec,
    output t_request o_req
);

    logic     r_valid;
    logic     n_valid;
    t_request r_req;
    logic     accept;

    assign o_exec  = r_valid && i_out_free;
    assign o_stall = r_valid && !i_out_free;
    assign accept  = i_valid && !o_stall;
    assign o_req   = r_req;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_exec) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.cmd          <= t_cmd'(i_cmd);
            r_req.app_id       <= i_app_id;
            r_req.priority_req <= i_priority_req;
        end
    end

endmodule

### rtl/core/pfa_engine.sv
// Command engine of the priority focus arbiter.
// Holds the client slot table and focus holder, and executes one request per cycle while i_exec is high.
// Depends on pfa_pkg.
module pfa_engine
    import pfa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_exec,
    input  t_request i_req,
    output t_result  o_res
);

    logic [SLOTS-1:0] r_active;
    logic [SLOTS-1:0] n_active;
    t_id              r_client [SLOTS];
    t_id              n_client [SLOTS];
    t_prio            r_prio [SLOTS];
    t_prio            n_prio [SLOTS];
    logic [SLOTS-1:0] r_prev_valid;
    logic [SLOTS-1:0] n_prev_valid;
    t_id              r_prev_client [SLOTS];
    t_id              n_prev_client [SLOTS];
    logic             r_holder_valid;
    logic             n_holder_valid;
    t_id              r_holder_client;
    t_id              n_holder_client;
    t_id              r_next_client;
    t_id              n_next_client;

    t_slot_vec m_id;
    t_slot_vec m_hold;
    t_slot_vec m_free;
    t_slot_vec m_prev;
    t_slot_idx s_idx;
    t_slot_idx h_idx;
    t_slot_idx f_idx;
    logic      s_found;
    logic      h_found;
    logic      f_found;
    logic      p_found;
    logic      h_prev_valid;
    t_id       h_prev_client;
    t_prio     sp;
    t_prio     hp;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            m_id[i]   = r_active[i] && (r_client[i] == i_req.app_id);
            m_hold[i] = r_active[i] && (r_client[i] == r_holder_client);
            m_free[i] = !r_active[i];
        end
    end

    assign s_found       = |m_id;
    assign h_found       = |m_hold;
    assign f_found       = |m_free;
    assign s_idx         = first_set(m_id);
    assign h_idx         = first_set(m_hold);
    assign f_idx         = first_set(m_free);
    assign h_prev_valid  = r_prev_valid[h_idx];
    assign h_prev_client = r_prev_client[h_idx];
    assign sp            = r_prio[s_idx];
    assign hp            = h_found ? r_prio[h_idx] : '0;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            m_prev[i] = r_active[i] && (r_client[i] == h_prev_client);
        end
    end

    assign p_found = |m_prev;

    always_comb begin
        n_active        = r_active;
        n_client        = r_client;
        n_prio          = r_prio;
        n_prev_valid    = r_prev_valid;
        n_prev_client   = r_prev_client;
        n_holder_valid  = r_holder_valid;
        n_holder_client = r_holder_client;
        n_next_client   = r_next_client;
        o_res           = '0;

        unique case (i_req.cmd)
            CMD_REGISTER: begin
                if (f_found) begin
                    n_active[f_idx]      = 1'b1;
                    n_client[f_idx]      = r_next_client;
                    n_prio[f_idx]        = PRIO_REGISTER;
                    n_prev_valid[f_idx]  = 1'b0;
                    n_prev_client[f_idx] = '0;
                    o_res.ok             = 1'b1;
                    o_res.new_id         = r_next_client;
                    n_next_client = (r_next_client == ID_MAX) ? ID_W'(1)
                                                              : r_next_client + ID_W'(1);
                end
            end
            CMD_UNREGISTER: begin
                if (s_found) begin
                    n_active[s_idx] = 1'b0;
                    n_prio[s_idx]   = PRIO_REGISTER;
                    if (r_holder_valid && (r_holder_client == i_req.app_id)) begin
                        n_holder_valid  = r_prev_valid[s_idx];
                        n_holder_client = r_prev_valid[s_idx] ? r_prev_client[s_idx] : '0;
                    end
                    n_prev_valid[s_idx]  = 1'b0;
                    n_prev_client[s_idx] = '0;
                end
            end
            CMD_REQUEST: begin
                if (!r_holder_valid || (r_holder_client == i_req.app_id)) begin
                    n_holder_valid  = 1'b1;
                    n_holder_client = i_req.app_id;
                    o_res.ok        = 1'b1;
                end else if (s_found && (sp > hp)) begin
                    n_prev_valid[s_idx]  = 1'b1;
                    n_prev_client[s_idx] = r_holder_client;
                    n_holder_client      = i_req.app_id;
                    o_res.ok             = 1'b1;
                    if (h_found) begin
                        o_res.lost_valid = 1'b1;
                        o_res.lost_id    = r_holder_client;
                    end
                end
            end
            CMD_RELEASE: begin
                if (r_holder_valid) begin
                    if (!h_found) begin
                        n_holder_valid  = 1'b0;
                        n_holder_client = '0;
                    end else begin
                        n_holder_valid       = h_prev_valid;
                        n_holder_client      = h_prev_valid ? h_prev_client : '0;
                        n_prev_valid[h_idx]  = 1'b0;
                        n_prev_client[h_idx] = '0;
                        if (h_prev_valid && p_found) begin
                            o_res.gained_valid = 1'b1;
                            o_res.gained_id    = h_prev_client;
                        end
                    end
                end
            end
            CMD_QUERY: begin
                o_res.ok = r_holder_valid && (r_holder_client == i_req.app_id);
            end
            CMD_SET_PRIO: begin
                if (s_found) begin
                    n_prio[s_idx] = (i_req.priority_req > PRIO_MAX_ID)
                                    ? PRIO_MAX_P : i_req.priority_req[PRIO_W-1:0];
                end
            end
            CMD_INC_PRIO: begin
                if (s_found && (sp < PRIO_MAX_P)) begin
                    n_prio[s_idx] = sp + PRIO_W'(1);
                end
            end
            CMD_DEC_PRIO: begin
                if (s_found && (sp != '0)) begin
                    n_prio[s_idx] = sp - PRIO_W'(1);
                end
            end
            default: begin
            end
        endcase

        o_res.focus_valid  = n_holder_valid;
        o_res.focus_holder = n_holder_valid ? n_holder_client : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active        <= '0;
            r_prev_valid    <= '0;
            r_holder_valid  <= 1'b0;
            r_holder_client <= '0;
            r_next_client   <= ID_W'(1);
            for (int i = 0; i < SLOTS; i++) begin
                r_client[i]      <= '0;
                r_prio[i]        <= '0;
                r_prev_client[i] <= '0;
            end
        end else if (i_exec) begin
            r_active        <= n_active;
            r_prev_valid    <= n_prev_valid;
            r_holder_valid  <= n_holder_valid;
            r_holder_client <= n_holder_client;
            r_next_client   <= n_next_client;
            for (int i = 0; i < SLOTS; i++) begin
                r_client[i]      <= n_client[i];
                r_prio[i]        <= n_prio[i];
                r_prev_client[i] <= n_prev_client[i];
            end
        end
    end

endmodule

### rtl/core/pfa_out_reg.sv
// Result register stage of the priority focus arbiter.
// Holds one finished result until the downstream side takes it.
// Depends on pfa_pkg.
module pfa_out_reg
    import pfa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

### rtl/core/priority_focus_arbiter.sv
// Priority focus arbiter: client slot table with focus grant, preemption and hand-back.
// An accepted request is executed once the result register is free, and its result is then
// registered onto the outputs; throughput is one request per cycle while i_stall is low,
// set by the single table update between the input and result registers.
// Synchronous active-low reset empties the table, clears the holder, sets the next id to one.
// Depends on pfa_pkg, pfa_in_reg, pfa_engine and pfa_out_reg.
module priority_focus_arbiter
    import pfa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_cmd,
    input  logic [7:0] i_app_id,
    input  logic [7:0] i_priority_req,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_ok,
    output logic [7:0] o_new_id,
    output logic       o_focus_valid,
    output logic [7:0] o_focus_holder,
    output logic       o_lost_valid,
    output logic [7:0] o_lost_id,
    output logic       o_gained_valid,
    output logic [7:0] o_gained_id
);

    t_request req;
    t_result  res;
    t_result  out_res;
    logic     exec;
    logic     out_free;

    pfa_in_reg u_in_reg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_cmd          (i_cmd),
        .i_app_id       (i_app_id),
        .i_priority_req (i_priority_req),
        .i_out_free     (out_free),
        .o_stall        (o_stall),
        .o_exec         (exec),
        .o_req          (req)
    );

    pfa_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_exec  (exec),
        .i_req   (req),
        .o_res   (res)
    );

    pfa_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (exec),
        .i_res   (res),
        .i_stall (i_stall),
        .o_free  (out_free),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_ok           = out_res.ok;
    assign o_new_id       = out_res.new_id;
    assign o_focus_valid  = out_res.focus_valid;
    assign o_focus_holder = out_res.focus_holder;
    assign o_lost_valid   = out_res.lost_valid;
    assign o_lost_id      = out_res.lost_id;
    assign o_gained_valid = out_res.gained_valid;
    assign o_gained_id    = out_res.gained_id;

    a_reset_empties_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_lost_means_granted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_lost_valid |-> o_ok && o_focus_valid && (o_focus_holder != o_lost_id))
        else $error("lost notice without a preempting grant");

    a_gained_is_holder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_gained_valid |-> o_focus_valid && (o_focus_holder == o_gained_id))
        else $error("gained notice does not match the new holder");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while the result stage can take a request");

endmodule

### tb/tb.sv
// Self-checking testbench for the priority focus arbiter: a directed script, an id wrap run
// and random command traffic, scored against this file's slot table model or row results.
// Depends on pfa_pkg and priority_focus_arbiter.
module tb;
    import pfa_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int LIMIT_CYCLES = 100000;
    localparam int SCRIPT_ROWS  = 21;
    localparam int HOLD_START   = 300;
    localparam int HOLD_CYCLES  = 64;
    localparam int FREE_START   = 1000;
    localparam int FREE_CYCLES  = 300;

    typedef struct packed {
        t_cmd       cmd;
        t_id        app_id;
        t_id        prio;
        logic [3:0] count;
        logic       typed;
        t_result    want;
    } t_script_row;

    localparam t_result QUIET = '0;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [2:0] i_cmd;
    t_id        i_app_id;
    t_id        i_priority_req;
    logic       o_valid;
    logic       i_stall;
    logic       o_ok;
    t_id        o_new_id;
    logic       o_focus_valid;
    t_id        o_focus_holder;
    logic       o_lost_valid;
    t_id        o_lost_id;
    logic       o_gained_valid;
    t_id        o_gained_id;

    logic slot_on      [SLOTS];
    t_id  slot_client  [SLOTS];
    t_id  slot_prio    [SLOTS];
    logic slot_prev_on [SLOTS];
    t_id  slot_prev    [SLOTS];
    logic holder_on;
    t_id  holder_id;
    t_id  next_client;
    t_id  last_new_id;
    logic ids_wrapped;

    t_result expected_focus [$];
    int      errors = 0;
    logic    steady = 1'b0;
    string   field_name [8] = '{"ok", "new_id", "focus_valid", "focus_holder",
                                "lost_valid", "lost_id", "gained_valid", "gained_id"};

    t_script_row script [SCRIPT_ROWS] = '{
        '{CMD_QUERY,      8'h00, 8'h00, 4'd1, 1'b1, QUIET},
        '{CMD_RELEASE,    8'hFF, 8'hFF, 4'd1, 1'b1, QUIET},
        '{CMD_REGISTER,   8'hFF, 8'hFF, 4'd1, 1'b1,
            '{1'b1, 8'd1, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0}},
        '{CMD_REGISTER,   8'h00, 8'h00, 4'd1, 1'b1,
            '{1'b1, 8'd2, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0}},
        '{CMD_REGISTER,   8'h5A, 8'hA5, 4'd8, 1'b0, QUIET},
        '{CMD_REGISTER,   8'h00, 8'h00, 4'd1, 1'b1, QUIET},
        '{CMD_REQUEST,    8'd1,  8'h00, 4'd1, 1'b1,
            '{1'b1, 8'd0, 1'b1, 8'd1, 1'b0, 8'd0, 1'b0, 8'd0}},
        '{CMD_REQUEST,    8'd2,  8'h00, 4'd1, 1'b1,
            '{1'b0, 8'd0, 1'b1, 8'd1, 1'b0, 8'd0, 1'b0, 8'd0}},
        '{CMD_SET_PRIO,   8'd2,  8'hFF, 4'd1, 1'b1,
            '{1'b0, 8'd0, 1'b1, 8'd1, 1'b0, 8'd0, 1'b0, 8'd0}},
        '{CMD_INC_PRIO,   8'd2,  8'h00, 4'd1, 1'b1,
            '{1'b0, 8'd0, 1'b1, 8'd1, 1'b0, 8'd0, 1'b0, 8'd0}},
        '{CMD_REQUEST,    8'd2,  8'h00, 4'd1, 1'b1,
            '{1'b1, 8'd0, 1'b1, 8'd2, 1'b1, 8'd1, 1'b0, 8'd0}},
        '{CMD_RELEASE,    8'hAA, 8'h55, 4'd1, 1'b1,
            '{1'b0, 8'd0, 1'b1, 8'd1, 1'b0, 8'd0, 1'b1, 8'd1}},
        '{CMD_DEC_PRIO,   8'd1,  8'h00, 4'd2, 1'b1,
            '{1'b0, 8'd0, 1'b1, 8'd1, 1'b0, 8'd0, 1'b0, 8'd0}},
        '{CMD_REQUEST,    8'd200, 8'h00, 4'd1, 1'b1,
            '{1'b0, 8'd0, 1'b1, 8'd1, 1'b0, 8'd0, 1'b0, 8'd0}},
        '{CMD_REQUEST,    8'd2,  8'h00, 4'd1, 1'b1,
            '{1'b1, 8'd0, 1'b1, 8'd2, 1'b1, 8'd1, 1'b0, 8'd0}},
        '{CMD_UNREGISTER, 8'd2,  8'h00, 4'd1, 1'b1,
            '{1'b0, 8'd0, 1'b1, 8'd1, 1'b0, 8'd0, 1'b0, 8'd0}},
        '{CMD_UNREGISTER, 8'd1,  8'h00, 4'd1, 1'b1, QUIET},
        '{CMD_REQUEST,    8'h80, 8'h00, 4'd1, 1'b1,
            '{1'b1, 8'd0, 1'b1, 8'h80, 1'b0, 8'd0, 1'b0, 8'd0}},
        '{CMD_REQUEST,    8'd3,  8'h00, 4'd1, 1'b1,
            '{1'b1, 8'd0, 1'b1, 8'd3, 1'b0, 8'd0, 1'b0, 8'd0}},
        '{CMD_RELEASE,    8'h00, 8'h00, 4'd1, 1'b1,
            '{1'b0, 8'd0, 1'b1, 8'h80, 1'b0, 8'd0, 1'b0, 8'd0}},
        '{CMD_RELEASE,    8'h00, 8'h00, 4'd1, 1'b1, QUIET}
    };

    priority_focus_arbiter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_app_id       (i_app_id),
        .i_priority_req (i_priority_req),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_ok           (o_ok),
        .o_new_id       (o_new_id),
        .o_focus_valid  (o_focus_valid),
        .o_focus_holder (o_focus_holder),
        .o_lost_valid   (o_lost_valid),
        .o_lost_id      (o_lost_id),
        .o_gained_valid (o_gained_valid),
        .o_gained_id    (o_gained_id)
    );

    always #2 i_clk = ~i_clk;

    // Only active slots match; with duplicate ids the lowest slot wins.
    function automatic int match_slot(input t_id id);
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_on[i] && slot_client[i] == id) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic t_result focus_step(input t_cmd c, input t_id id, input t_id preq);
        t_result r;
        int      s;
        int      h;
        t_id     hp;
        r = '0;
        case (c)
            CMD_REGISTER: begin
                s = -1;
                for (int i = SLOTS - 1; i >= 0; i--) begin
                    if (!slot_on[i]) begin
                        s = i;
                    end
                end
                if (s >= 0) begin
                    slot_on[s]      = 1'b1;
                    slot_client[s]  = next_client;
                    slot_prio[s]    = 8'd1;
                    slot_prev_on[s] = 1'b0;
                    slot_prev[s]    = '0;
                    r.ok            = 1'b1;
                    r.new_id        = next_client;
                    last_new_id     = next_client;
                    if (next_client == ID_MAX) begin
                        next_client = 8'd1;
                        ids_wrapped = 1'b1;
                    end else begin
                        next_client = next_client + 8'd1;
                    end
                end
            end
            CMD_UNREGISTER: begin
                s = match_slot(id);
                if (s >= 0) begin
                    slot_on[s]   = 1'b0;
                    slot_prio[s] = 8'd1;
                    if (holder_on && holder_id == id) begin
                        holder_on = slot_prev_on[s];
                        holder_id = slot_prev_on[s] ? slot_prev[s] : '0;
                    end
                    slot_prev_on[s] = 1'b0;
                    slot_prev[s]    = '0;
                end
            end
            CMD_REQUEST: begin
                if (!holder_on || holder_id == id) begin
                    holder_on = 1'b1;
                    holder_id = id;
                    r.ok      = 1'b1;
                end else begin
                    s  = match_slot(id);
                    h  = match_slot(holder_id);
                    hp = (h >= 0) ? slot_prio[h] : '0;
                    if (s >= 0 && slot_prio[s] > hp) begin
                        slot_prev_on[s] = 1'b1;
                        slot_prev[s]    = holder_id;
                        if (h >= 0) begin
                            r.lost_valid = 1'b1;
                            r.lost_id    = holder_id;
                        end
                        holder_id = id;
                        r.ok      = 1'b1;
                    end
                end
            end
            CMD_RELEASE: begin
                if (holder_on) begin
                    h = match_slot(holder_id);
                    if (h < 0) begin
                        holder_on = 1'b0;
                        holder_id = '0;
                    end else begin
                        holder_on       = slot_prev_on[h];
                        holder_id       = slot_prev_on[h] ? slot_prev[h] : '0;
                        slot_prev_on[h] = 1'b0;
                        slot_prev[h]    = '0;
                        if (holder_on && match_slot(holder_id) >= 0) begin
                            r.gained_valid = 1'b1;
                            r.gained_id    = holder_id;
                        end
                    end
                end
            end
            CMD_QUERY: begin
                r.ok = holder_on && holder_id == id;
            end
            CMD_SET_PRIO: begin
                s = match_slot(id);
                if (s >= 0) begin
                    slot_prio[s] = (preq > PRIO_MAX_ID) ? PRIO_MAX_ID : preq;
                end
            end
            CMD_INC_PRIO: begin
                s = match_slot(id);
                if (s >= 0 && slot_prio[s] < PRIO_MAX_ID) begin
                    slot_prio[s] = slot_prio[s] + 8'd1;
                end
            end
            default: begin
                s = match_slot(id);
                if (s >= 0 && slot_prio[s] > 0) begin
                    slot_prio[s] = slot_prio[s] - 8'd1;
                end
            end
        endcase
        r.focus_valid  = holder_on;
        r.focus_holder = holder_on ? holder_id : '0;
        return r;
    endfunction

    // Offers one request, holds it until accepted, then books its expected result.
    task automatic offer(input t_cmd c, input t_id a, input t_id p,
                         input logic typed, input t_result want);
        t_result predicted;
        while (!steady && $urandom_range(99) < 35) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_cmd          <= c;
        i_app_id       <= a;
        i_priority_req <= p;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        predicted = focus_step(c, a, p);
        expected_focus.push_back(typed ? want : predicted);
    endtask

    initial begin : result_sink
        int unsigned cyc;
        cyc = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) begin
                i_stall <= 1'b1;
            end else if (cyc >= FREE_START && cyc < FREE_START + FREE_CYCLES) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < 35);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result   seen;
        t_result   want;
        logic [7:0] want_f [8];
        logic [7:0] seen_f [8];
        if (i_rst_n && o_valid && !i_stall) begin
            seen = '{o_ok, o_new_id, o_focus_valid, o_focus_holder,
                     o_lost_valid, o_lost_id, o_gained_valid, o_gained_id};
            if (expected_focus.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, seen);
                errors++;
            end else begin
                want   = expected_focus.pop_front();
                want_f = '{8'(want.ok), want.new_id,
                           8'(want.focus_valid), want.focus_holder,
                           8'(want.lost_valid), want.lost_id,
                           8'(want.gained_valid), want.gained_id};
                seen_f = '{8'(seen.ok), seen.new_id,
                           8'(seen.focus_valid), seen.focus_holder,
                           8'(seen.lost_valid), seen.lost_id,
                           8'(seen.gained_valid), seen.gained_id};
                for (int f = 0; f < 8; f++) begin
                    if (want_f[f] !== seen_f[f]) begin
                        $display("%0t: %s expected %h, got %h",
                                 $time, field_name[f], want_f[f], seen_f[f]);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin : watchdog
        #(LIMIT_CYCLES * 4);
        $display("FAIL priority_focus_arbiter");
        $finish;
    end

    initial begin : stimulus
        t_cmd c;
        t_id  a;
        t_id  p;
        int   pick;
        int   s;
        for (int i = 0; i < SLOTS; i++) begin
            slot_on[i]      = 1'b0;
            slot_client[i]  = '0;
            slot_prio[i]    = '0;
            slot_prev_on[i] = 1'b0;
            slot_prev[i]    = '0;
        end
        holder_on      = 1'b0;
        holder_id      = '0;
        next_client    = 8'd1;
        last_new_id    = '0;
        ids_wrapped    = 1'b0;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_cmd          <= CMD_QUERY;
        i_app_id       <= '0;
        i_priority_req <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int row = 0; row < SCRIPT_ROWS; row++) begin
            for (int k = 0; k < script[row].count; k++) begin
                offer(script[row].cmd, script[row].app_id, script[row].prio,
                      script[row].typed, script[row].want);
            end
        end

        // Cycle clients through a free slot until the id counter has wrapped past zero.
        while (!ids_wrapped) begin
            offer(CMD_REGISTER, t_id'($urandom_range(255)), t_id'($urandom_range(255)),
                  1'b0, QUIET);
            offer(CMD_UNREGISTER, last_new_id, t_id'($urandom_range(255)), 1'b0, QUIET);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 100 && n < 250);
            if (n == 300) begin
                i_valid <= 1'b0;
                do @(posedge i_clk); while (expected_focus.size() != 0);
            end
            pick = $urandom_range(99);
            if (pick < 14) begin
                c = CMD_REGISTER;
            end else if (pick < 26) begin
                c = CMD_UNREGISTER;
            end else if (pick < 48) begin
                c = CMD_REQUEST;
            end else if (pick < 60) begin
                c = CMD_RELEASE;
            end else if (pick < 68) begin
                c = CMD_QUERY;
            end else if (pick < 78) begin
                c = CMD_SET_PRIO;
            end else if (pick < 89) begin
                c = CMD_INC_PRIO;
            end else begin
                c = CMD_DEC_PRIO;
            end
            pick = $urandom_range(99);
            s    = $urandom_range(SLOTS - 1);
            for (int k = 0; k < SLOTS && !slot_on[s]; k++) begin
                s = (s + 1) % SLOTS;
            end
            if (pick < 20) begin
                a = t_id'($urandom_range(255));
            end else if (pick < 35 && holder_on) begin
                a = holder_id;
            end else if (slot_on[s]) begin
                a = slot_client[s];
            end else begin
                a = t_id'($urandom_range(255));
            end
            p = $urandom_range(1) ? t_id'($urandom_range(255))
                                  : t_id'($urandom_range(PRIO_MAX + 1));
            offer(c, a, p, 1'b0, QUIET);
        end

        steady  = 1'b0;
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_focus.size() != 0);
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS priority_focus_arbiter");
        end else begin
            $display("FAIL priority_focus_arbiter");
        end
        $finish;
    end

endmodule
